@@ sv/trlsu_pkg.sv @@
// Shared constants, codes and types of the two-region level set update block.
package trlsu_pkg;

  localparam int PIXEL_BITS       = 8;
  localparam int FRAME_COUNT_BITS = 20;
  localparam int LEVEL_BITS       = 16;

  localparam int PIX_W   = 8;
  localparam int LVL_W   = 16;
  localparam int CURV_W  = 16;
  localparam int MEAN_W  = 16;
  localparam int FORCE_W = 26;
  localparam int TSTEP_W = 16;
  localparam int SUM_W   = PIXEL_BITS + FRAME_COUNT_BITS + 1;
  localparam int CNT_W   = FRAME_COUNT_BITS + 1;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = FORCE_W + 1;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // level sum before saturation: level + step + curvature
  localparam int NL_W = 29;

  localparam logic [TSTEP_W-1:0] TSTEP_RESET = 16'd6554;

  localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};
  localparam logic [LVL_W-1:0]   LVL_MAX   = {1'b0, {(LVL_W-1){1'b1}}};
  localparam logic [LVL_W-1:0]   LVL_MIN   = {1'b1, {(LVL_W-1){1'b0}}};

  localparam logic REQ_STATS  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_IN_START,
    S_DIV_IN_WAIT,
    S_DIV_OUT_START,
    S_DIV_OUT_WAIT,
    S_EMIT_SUM,
    S_MUL_DATA,
    S_FORCE,
    S_MUL_STEP,
    S_EMIT_PIX
  } trlsu_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ sv/trlsu_if.sv @@
// Request and result channel interfaces of the level set update block.
interface trlsu_req_if import trlsu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [PIX_W-1:0]         intensity;
  logic signed [LVL_W-1:0]  level;
  logic                     in_band;
  logic signed [CURV_W-1:0] curvature_term;
  logic                     end_of_pass;

  modport source (output valid, req_type, intensity, level, in_band, curvature_term,
                  end_of_pass, input ready);
  modport sink   (input valid, req_type, intensity, level, in_band, curvature_term,
                  end_of_pass, output ready);
endinterface

interface trlsu_res_if import trlsu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [MEAN_W-1:0]         mean_inside;
  logic [MEAN_W-1:0]         mean_outside;
  logic                      region_empty;
  logic signed [FORCE_W-1:0] force_res;
  logic signed [LVL_W-1:0]   new_level;
  logic                      saturated;
  logic                      frame_done;

  modport source (output valid, result_kind, mean_inside, mean_outside, region_empty,
                  force_res, new_level, saturated, frame_done, input ready);
  modport sink   (input valid, result_kind, mean_inside, mean_outside, region_empty,
                  force_res, new_level, saturated, frame_done, output ready);
endinterface

@@ sv/trlsu_div.sv @@
// Iterative restoring divider for the region means: floor(sum*256/count), clamped.
module trlsu_div import trlsu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [CNT_W-1:0]  cnt_i,
  output div_stat_t         stat_o,
  output logic [MEAN_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(MEAN_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [MEAN_W-1:0] quo_q, quo_d;
  logic [MEAN_W-1:0] sh_q, sh_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              overflow;

  // quotient needs more than MEAN_W bits exactly when sum >= count*256
  assign overflow = ((SUM_W+1)'({cnt_i, 8'h00}) <= {1'b0, sum_i});
  assign trial    = {rem_q, sh_q[MEAN_W-1]};
  assign diff     = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    sh_d   = sh_q;
    if (start_i) begin
      dvs_d = cnt_i;
      if (cnt_i == '0) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else if (overflow) begin
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = CNT_W'(sum_i >> 8);
        sh_d   = {sum_i[7:0], 8'h00};
        quo_d  = '0;
        step_d = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!diff[CNT_W]) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[MEAN_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[MEAN_W-2:0], 1'b0};
      end
      sh_d   = {sh_q[MEAN_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(MEAN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    sh_q  <= sh_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

@@ sv/trlsu_mul.sv @@
// Shared signed multiplier with registered product, used for force and step terms.
module trlsu_mul import trlsu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

@@ sv/two_region_level_set_update_top.sv @@
// Top level of the two-region level set update: sequencer, accumulators, output register.
//
// Requests arrive on req (valid/ready), results leave on res (valid/ready).
// A statistics request (req_type 0) is folded into the region sums in the
// cycle it is accepted; only the last one of a pass gives a result. That
// one runs two 16-step divisions on the shared divider and then presents
// the means summary (a division ends at once if its region is empty or its
// mean clamps). An update request (req_type 1) makes two passes through the
// shared multiplier (data force, then dt*force), one force saturation step
// and the final level add before its result is presented. The sequencer
// handles one request at a time; ready is high only while it is idle and
// comes back in the cycle the result appears. A request that gives no
// result leaves it idle, so those go back to back.
// The result sits in an output register, so a new request is taken while
// the last result still waits; a stalled receiver only holds the sequencer
// in its final step until the register frees up.
// time_step is to be written through cfg_we_i/cfg_wdata_i only while the
// block is idle; the block itself does not enforce this.
// Reset clears sums, counts and means and loads time_step with 6554.
module two_region_level_set_update_top import trlsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  trlsu_req_if.sink          req,
  trlsu_res_if.source        res,
  input  logic               cfg_we_i,
  input  logic [TSTEP_W-1:0] cfg_wdata_i
);

  trlsu_state_e state_q, state_d;

  logic [TSTEP_W-1:0] tstep_q;
  logic [SUM_W-1:0]   in_sum_q, out_sum_q;
  logic [CNT_W-1:0]   in_cnt_q, out_cnt_q, pos_cnt_q;
  logic [MEAN_W-1:0]  c1_q, c2_q;
  logic               empty_q;

  logic [PIXEL_BITS-1:0]    pix_q;
  logic signed [LVL_W-1:0]  lvl_q;
  logic                     band_q;
  logic signed [CURV_W-1:0] curv_q;
  logic                     last_q;
  logic [FORCE_W-1:0]       force_q;

  logic                      out_valid_q;
  logic                      out_kind_q;
  logic [MEAN_W-1:0]         out_c1_q, out_c2_q;
  logic                      out_empty_q;
  logic [FORCE_W-1:0]        out_force_q;
  logic [LVL_W-1:0]          out_nl_q;
  logic                      out_sat_q;
  logic                      out_done_q;

  // sequencer controls
  logic req_ready;
  logic div_start;
  logic div_sel_out;
  logic mul_en;
  logic mul_step;
  logic force_load;
  logic c1_load;
  logic c2_load;
  logic out_load;
  logic slot_free;

  logic accept;
  logic [PIXEL_BITS-1:0] pix_in;
  logic [SUM_W:0] in_sum_add, out_sum_add;

  div_stat_t         div_stat;
  logic [MEAN_W-1:0] div_quot;
  logic [SUM_W-1:0]  div_sum;
  logic [CNT_W-1:0]  div_cnt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [MEAN_W:0]           mean_diff;
  logic [MUL_B_W-1:0]        data_term;

  logic [PROD_W-9:0]  prod_sh;
  logic               force_fits;
  logic [FORCE_W-1:0] force_d;
  logic [MUL_A_W-1:0] step_val;
  logic [NL_W-1:0]    nl_sum;
  logic               nl_fits;
  logic [LVL_W-1:0]   nl_val;
  logic               nl_sat;

  assign accept    = req.valid && req.ready;
  assign pix_in    = req.intensity[PIXEL_BITS-1:0];
  assign slot_free = !out_valid_q || res.ready;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_UPDATE) begin
            state_d = S_MUL_DATA;
          end else if (req.end_of_pass) begin
            state_d = S_DIV_IN_START;
          end
        end
      end
      S_DIV_IN_START:  state_d = S_DIV_IN_WAIT;
      S_DIV_IN_WAIT: begin
        if (div_stat.done) begin
          state_d = S_DIV_OUT_START;
        end
      end
      S_DIV_OUT_START: state_d = S_DIV_OUT_WAIT;
      S_DIV_OUT_WAIT: begin
        if (div_stat.done) begin
          state_d = S_EMIT_SUM;
        end
      end
      S_EMIT_SUM: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      S_MUL_DATA: state_d = S_FORCE;
      S_FORCE:    state_d = S_MUL_STEP;
      S_MUL_STEP: state_d = S_EMIT_PIX;
      S_EMIT_PIX: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    div_start   = 1'b0;
    div_sel_out = 1'b0;
    mul_en      = 1'b0;
    mul_step    = 1'b0;
    force_load  = 1'b0;
    c1_load     = 1'b0;
    c2_load     = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      S_IDLE:          req_ready = 1'b1;
      S_DIV_IN_START:  div_start = 1'b1;
      S_DIV_IN_WAIT:   c1_load = div_stat.done;
      S_DIV_OUT_START: begin
        div_start   = 1'b1;
        div_sel_out = 1'b1;
      end
      S_DIV_OUT_WAIT:  c2_load = div_stat.done;
      S_EMIT_SUM:      out_load = slot_free;
      S_MUL_DATA:      mul_en = 1'b1;
      S_FORCE:         force_load = 1'b1;
      S_MUL_STEP: begin
        mul_en   = 1'b1;
        mul_step = 1'b1;
      end
      S_EMIT_PIX:      out_load = slot_free;
      default:         req_ready = 1'b0;
    endcase
  end

  assign req.ready = req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstep_q <= TSTEP_RESET;
    end else if (cfg_we_i) begin
      tstep_q <= cfg_wdata_i;
    end
  end

  // ---------------- region statistics ----------------
  assign in_sum_add  = {1'b0, in_sum_q} + (SUM_W+1)'(pix_in);
  assign out_sum_add = {1'b0, out_sum_q} + (SUM_W+1)'(pix_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sum_q  <= '0;
      out_sum_q <= '0;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      pos_cnt_q <= '0;
    end else if (c2_load) begin
      in_sum_q  <= '0;
      out_sum_q <= '0;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      pos_cnt_q <= '0;
    end else if (accept && req.req_type == REQ_STATS) begin
      if (req.level[LVL_W-1]) begin
        in_sum_q <= in_sum_add[SUM_W] ? '1 : in_sum_add[SUM_W-1:0];
        if (in_cnt_q != '1) begin
          in_cnt_q <= in_cnt_q + 1'b1;
        end
      end else begin
        out_sum_q <= out_sum_add[SUM_W] ? '1 : out_sum_add[SUM_W-1:0];
        if (out_cnt_q != '1) begin
          out_cnt_q <= out_cnt_q + 1'b1;
        end
        // hold positive count on a level of exactly zero
        if (req.level != '0 && pos_cnt_q != '1) begin
          pos_cnt_q <= pos_cnt_q + 1'b1;
        end
      end
    end
  end

  assign div_sum = div_sel_out ? out_sum_q : in_sum_q;
  assign div_cnt = div_sel_out ? out_cnt_q : in_cnt_q;

  trlsu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (div_sum),
    .cnt_i  (div_cnt),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q    <= '0;
      c2_q    <= '0;
      empty_q <= 1'b0;
    end else begin
      if (c1_load) begin
        c1_q <= div_quot;
      end
      if (c2_load) begin
        c2_q    <= div_quot;
        empty_q <= (in_cnt_q == '0) || (pos_cnt_q == '0);
      end
    end
  end

  // ---------------- update pixel ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= pix_in;
      lvl_q  <= req.level;
      band_q <= req.in_band;
      curv_q <= req.curvature_term;
      last_q <= req.end_of_pass;
    end
    if (force_load) begin
      force_q <= force_d;
    end
  end

  // c1 - c2 and c1 + c2 - 2*I (all Q8.8)
  assign mean_diff = {1'b0, c1_q} - {1'b0, c2_q};
  assign data_term = {3'b000, c1_q} + {3'b000, c2_q} - {2'b00, PIX_W'(pix_q), 9'h000};

  always_comb begin
    if (mul_step) begin
      mul_a = {force_q[FORCE_W-1], force_q};
      mul_b = {3'b000, tstep_q};
    end else begin
      mul_a = {{(MUL_A_W-MEAN_W-1){mean_diff[MEAN_W]}}, mean_diff};
      mul_b = data_term;
    end
  end

  trlsu_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // floor to Q.8 is an arithmetic drop of the low bits; saturate to the force range
  assign prod_sh    = prod[PROD_W-1:8];
  assign force_fits = (&prod_sh[PROD_W-9:FORCE_W-1]) || !(|prod_sh[PROD_W-9:FORCE_W-1]);
  assign force_d    = force_fits ? prod_sh[FORCE_W-1:0]
                                 : (prod_sh[PROD_W-9] ? FORCE_MIN : FORCE_MAX);

  assign step_val = prod[MUL_A_W+15:16];
  assign nl_sum   = {{(NL_W-LVL_W){lvl_q[LVL_W-1]}}, lvl_q}
                  + {{(NL_W-MUL_A_W){step_val[MUL_A_W-1]}}, step_val}
                  + {{(NL_W-CURV_W){curv_q[CURV_W-1]}}, curv_q};
  assign nl_fits  = (&nl_sum[NL_W-1:LEVEL_BITS-1]) || !(|nl_sum[NL_W-1:LEVEL_BITS-1]);

  always_comb begin
    if (!band_q) begin
      nl_val = lvl_q;
      nl_sat = 1'b0;
    end else if (nl_fits) begin
      nl_val = nl_sum[LVL_W-1:0];
      nl_sat = 1'b0;
    end else begin
      nl_val = nl_sum[NL_W-1] ? LVL_MIN : LVL_MAX;
      nl_sat = 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_c1_q    <= c1_q;
      out_c2_q    <= c2_q;
      out_empty_q <= empty_q;
      if (state_q == S_EMIT_PIX) begin
        out_kind_q  <= KIND_PIXEL;
        out_force_q <= force_q;
        out_nl_q    <= nl_val;
        out_sat_q   <= nl_sat;
        out_done_q  <= last_q;
      end else begin
        out_kind_q  <= KIND_SUMMARY;
        out_force_q <= '0;
        out_nl_q    <= '0;
        out_sat_q   <= 1'b0;
        out_done_q  <= 1'b1;
      end
    end
  end

  assign res.valid        = out_valid_q;
  assign res.result_kind  = out_kind_q;
  assign res.mean_inside  = out_c1_q;
  assign res.mean_outside = out_c2_q;
  assign res.region_empty = out_empty_q;
  assign res.force_res    = out_force_q;
  assign res.new_level    = out_nl_q;
  assign res.saturated    = out_sat_q;
  assign res.frame_done   = out_done_q;

  // ---------------- assertions ----------------
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_stats_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_load |=> (in_cnt_q == '0 && out_cnt_q == '0 && pos_cnt_q == '0))
    else $error("region statistics not cleared after means");

  a_unbanded_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && state_q == S_EMIT_PIX && !band_q)
      |=> (!res.saturated && res.new_level == $past(lvl_q)))
    else $error("pixel outside band was modified");

  a_summary_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && state_q == S_EMIT_SUM) |=> (res.frame_done && res.force_res == '0))
    else $error("summary result fields wrong");

endmodule

@@ dv/trlsu_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts and compares the results of the level set update block.
module trlsu_checker import trlsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  trlsu_req_if               req,
  trlsu_res_if               res,
  input  logic               cfg_we_i,
  input  logic [TSTEP_W-1:0] cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 64'd1;
  localparam longint FORCE_HI = (longint'(1) <<< (FORCE_W - 1)) - 1;
  localparam longint FORCE_LO = -FORCE_HI - 1;
  localparam longint LEVEL_HI = (longint'(1) <<< (LEVEL_BITS - 1)) - 1;
  localparam longint LEVEL_LO = -LEVEL_HI - 1;

  typedef struct packed {
    logic                      kind;
    logic [MEAN_W-1:0]         c_in;
    logic [MEAN_W-1:0]         c_out;
    logic                      empty;
    logic signed [FORCE_W-1:0] force_val;
    logic signed [LVL_W-1:0]   lvl;
    logic                      sat;
    logic                      last;
  } level_result_t;

  level_result_t expected_q[$];
  int fails = 0;

  logic [TSTEP_W-1:0] step_q;
  logic [SUM_W-1:0]   sum_in, sum_out;
  logic [CNT_W-1:0]   cnt_in, cnt_out, cnt_pos;
  logic [MEAN_W-1:0]  mean_in, mean_out;
  logic               empty_q;

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                              longint unsigned max);
    return (a + b > max) ? max : a + b;
  endfunction

  function automatic logic [MEAN_W-1:0] region_mean(longint unsigned sum,
                                                    longint unsigned cnt);
    longint unsigned q;
    if (cnt == 0) return '0;
    q = (sum << 8) / cnt;
    return (q > 65535) ? 16'hFFFF : q[MEAN_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Fold one accepted request into the region state; queue the result it causes.
  task automatic fold_request();
    level_result_t r;
    longint lvl, curv, pix, c_in, c_out, prod, frc, nl;
    r = '0;
    lvl = req.level;
    curv = req.curvature_term;
    pix = longint'(req.intensity);
    if (req.req_type == REQ_STATS) begin
      if (lvl < 0) begin
        sum_in = SUM_W'(sat_sum(sum_in, pix, SUM_MAX));
        cnt_in = CNT_W'(sat_sum(cnt_in, 1, CNT_MAX));
      end else begin
        sum_out = SUM_W'(sat_sum(sum_out, pix, SUM_MAX));
        cnt_out = CNT_W'(sat_sum(cnt_out, 1, CNT_MAX));
        if (lvl > 0) cnt_pos = CNT_W'(sat_sum(cnt_pos, 1, CNT_MAX));
      end
      if (!req.end_of_pass) return;
      mean_in = region_mean(sum_in, cnt_in);
      mean_out = region_mean(sum_out, cnt_out);
      empty_q = (cnt_in == 0) || (cnt_pos == 0);
      sum_in = '0;
      sum_out = '0;
      cnt_in = '0;
      cnt_out = '0;
      cnt_pos = '0;
      r.kind = KIND_SUMMARY;
      r.last = 1'b1;
    end else begin
      c_in = longint'(mean_in);
      c_out = longint'(mean_out);
      prod = (c_in + c_out - pix * 512) * (c_in - c_out);
      frc = prod >>> 8;
      if (frc > FORCE_HI) frc = FORCE_HI;
      if (frc < FORCE_LO) frc = FORCE_LO;
      nl = lvl;
      if (req.in_band) begin
        nl = lvl + ((longint'(step_q) * frc) >>> 16) + curv;
        if (nl > LEVEL_HI) begin
          nl = LEVEL_HI;
          r.sat = 1'b1;
        end else if (nl < LEVEL_LO) begin
          nl = LEVEL_LO;
          r.sat = 1'b1;
        end
      end
      r.kind = KIND_PIXEL;
      r.force_val = frc[FORCE_W-1:0];
      r.lvl = nl[LVL_W-1:0];
      r.last = req.end_of_pass;
    end
    r.c_in = mean_in;
    r.c_out = mean_out;
    r.empty = empty_q;
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    level_result_t want;
    if (!rst_ni) begin
      step_q = TSTEP_RESET;
      sum_in = '0;
      sum_out = '0;
      cnt_in = '0;
      cnt_out = '0;
      cnt_pos = '0;
      mean_in = '0;
      mean_out = '0;
      empty_q = 1'b0;
      expected_q.delete();
    end else begin
      // compare before predicting: a request never yields its result in the same cycle
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $error("result_kind %0d arrived with no request pending", res.result_kind);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", want.kind, res.result_kind);
          check_field("mean_inside", want.c_in, res.mean_inside);
          check_field("mean_outside", want.c_out, res.mean_outside);
          check_field("region_empty", want.empty, res.region_empty);
          check_field("force_res", $signed(want.force_val), $signed(res.force_res));
          check_field("new_level", $signed(want.lvl), $signed(res.new_level));
          check_field("saturated", want.sat, res.saturated);
          check_field("frame_done", want.last, res.frame_done);
        end
      end
      if (cfg_we_i) step_q = cfg_wdata_i;
      if (req.valid && req.ready) fold_request();
    end
    pending_o <= expected_q.size();
    fail_count_o <= fails;
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and stall stimulus, and the final verdict.
module tb;
  import trlsu_pkg::*;

  typedef enum int {LVL_INSIDE, LVL_OUTSIDE, LVL_ZERO, LVL_MIXED} level_mix_e;
  typedef enum int {RDY_OPEN, RDY_COIN, RDY_PERIODIC, RDY_SPARSE} ready_mode_e;

  localparam int SETTLE_CYCLES   = 48;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEM_TARGET     = 1900;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [TSTEP_W-1:0] cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 items_sent;
  int                 burst_left;
  bit                 hold_off = 1'b0;

  trlsu_req_if req_ch ();
  trlsu_res_if res_ch ();

  two_region_level_set_update_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .res         (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  trlsu_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .res          (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #1ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one request; open a new burst after a random gap when the last one ran out.
  task automatic send(input logic rtype, input logic [PIX_W-1:0] pix,
                      input logic signed [LVL_W-1:0] lvl, input logic band,
                      input logic signed [CURV_W-1:0] curv, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= rtype;
    req_ch.intensity      <= pix;
    req_ch.level          <= lvl;
    req_ch.in_band        <= band;
    req_ch.curvature_term <= curv;
    req_ch.end_of_pass    <= last;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every result is back and the sequencer is idle.
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [TSTEP_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] pick_pix();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom);
  endfunction

  function automatic logic signed [LVL_W-1:0] pick_level(level_mix_e mix);
    logic signed [LVL_W-1:0] v;
    v = LVL_W'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0: v = LVL_MIN;
        1: v = LVL_MAX;
        2: v = '0;
        3: v = -16'sd1;
        default: v = 16'sd1;
      endcase
    end
    case (mix)
      LVL_INSIDE: if (v >= 0) v = ~v;
      LVL_OUTSIDE: if (v < 0) v = ~v;
      LVL_ZERO: v = '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [CURV_W-1:0] pick_curv();
    case ($urandom_range(0, 3))
      0: return CURV_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return CURV_W'(int'($urandom_range(0, 1023)) - 512);
    endcase
  endfunction

  function automatic level_mix_e pick_mix();
    if ($urandom_range(0, 3) == 0) return level_mix_e'($urandom_range(0, 2));
    return LVL_MIXED;
  endfunction

  // Mostly short frames, now and then a long one.
  function automatic int frame_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(64, 160) : $urandom_range(1, 16);
  endfunction

  task automatic stats_pass(input int n, input level_mix_e mix);
    for (int i = 0; i < n; i++)
      send(REQ_STATS, pick_pix(), pick_level(mix), 1'($urandom), pick_curv(), i == n - 1);
  endtask

  task automatic update_pass(input int n);
    for (int i = 0; i < n; i++)
      send(REQ_UPDATE, pick_pix(), pick_level(LVL_MIXED), $urandom_range(0, 3) != 0,
           pick_curv(), i == n - 1);
  endtask

  task automatic noise(input int n);
    for (int i = 0; i < n; i++)
      send(1'($urandom), pick_pix(), pick_level(LVL_MIXED), 1'($urandom), pick_curv(),
           $urandom_range(0, 3) == 0);
  endtask

  // Receiver: segments of open, coin-flip, periodic and sparse ready, plus one long hold.
  initial begin
    ready_mode_e mode;
    int seg, period;
    bit held;
    held = 1'b0;
    forever begin
      if (hold_off && !held) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        held = 1'b1;
      end else begin
        mode = ready_mode_e'($urandom_range(0, 3));
        seg = $urandom_range(20, 120);
        period = $urandom_range(2, 6);
        for (int i = 0; i < seg && !(hold_off && !held); i++) begin
          case (mode)
            RDY_OPEN: res_ch.ready <= 1'b1;
            RDY_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
            RDY_PERIODIC: res_ch.ready <= (i % period) != 0;
            default: res_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int frame_no;
    rst_ni                <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_STATS;
    req_ch.intensity      <= '0;
    req_ch.level          <= '0;
    req_ch.in_band        <= 1'b0;
    req_ch.curvature_term <= '0;
    req_ch.end_of_pass    <= 1'b0;
    items_sent = 0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // update before any statistics: means are zero, clip both ways, out of band
    send(REQ_UPDATE, 8'hFF, LVL_MAX, 1'b1, 16'sh7FFF, 1'b0);
    send(REQ_UPDATE, 8'h00, LVL_MIN, 1'b1, 16'sh8000, 1'b0);
    send(REQ_UPDATE, 8'd128, 16'sd1234, 1'b0, 16'sd500, 1'b1);
    // all pixels inside: no positive level, outside region empty
    send(REQ_STATS, 8'h00, -16'sd1, 1'b1, 16'sh7FFF, 1'b0);
    send(REQ_STATS, 8'hFF, LVL_MIN, 1'b0, 16'sh8000, 1'b0);
    send(REQ_STATS, 8'd100, -16'sd256, 1'b1, 16'sd0, 1'b1);
    // zero levels count as outside but not positive
    send(REQ_STATS, 8'd40, 16'sd0, 1'b0, 16'sd0, 1'b0);
    send(REQ_STATS, 8'd90, 16'sd0, 1'b0, 16'sd0, 1'b1);
    // single-pixel pass, inside region empty
    send(REQ_STATS, 8'hFF, 16'sd1, 1'b0, 16'sd0, 1'b1);
    // widest mean spread
    send(REQ_STATS, 8'h00, -16'sd5, 1'b0, 16'sd0, 1'b0);
    send(REQ_STATS, 8'hFF, LVL_MAX, 1'b0, 16'sd0, 1'b1);
    write_step(16'hFFFF);
    send(REQ_UPDATE, 8'h00, 16'sd0, 1'b1, 16'sd0, 1'b0);
    send(REQ_UPDATE, 8'hFF, 16'sd0, 1'b1, 16'sd0, 1'b0);
    send(REQ_UPDATE, 8'd128, 16'sd300, 1'b1, -16'sd20, 1'b0);
    send(REQ_UPDATE, 8'hFF, LVL_MIN, 1'b0, 16'sd0, 1'b1);
    write_step('0);
    send(REQ_UPDATE, 8'hFF, 16'sd100, 1'b1, -16'sd100, 1'b1);
    // inside brighter than outside
    send(REQ_STATS, 8'hFF, -16'sd1, 1'b0, 16'sd0, 1'b0);
    send(REQ_STATS, 8'd10, 16'sd3, 1'b0, 16'sd0, 1'b1);
    write_step(TSTEP_RESET);
    send(REQ_UPDATE, 8'd200, -16'sd700, 1'b1, 16'sd64, 1'b1);

    frame_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (frame_no % 12 == 11) begin
        case ($urandom_range(0, 3))
          0: write_step('0);
          1: write_step('1);
          2: write_step(TSTEP_RESET);
          default: write_step(TSTEP_W'($urandom));
        endcase
      end
      if (frame_no == 3) begin
        // keep offering updates while the receiver holds off
        stats_pass(48, LVL_MIXED);
        hold_off = 1'b1;
        update_pass(48);
      end else begin
        case ($urandom_range(0, 9))
          0: noise($urandom_range(8, 24));
          1: stats_pass(frame_len(), pick_mix());
          2: update_pass(frame_len());
          default: begin
            stats_pass(frame_len(), pick_mix());
            update_pass(frame_len());
          end
        endcase
      end
      frame_no++;
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
